### rtl/coe_pkg.sv
// Types and constants shared by the option encoder modules.
package coe_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [16:0] NIB_DIRECT_MAX = 17'd12;
  localparam logic [16:0] EXT1_BASE      = 17'd13;
  localparam logic [16:0] EXT1_MAX       = 17'd268;
  localparam logic [16:0] EXT2_BASE      = 17'd269;
  localparam logic [16:0] MAX_OPAQUE_LEN = 17'd65804;
  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_EXT2       = 4'd14;
  localparam logic [31:0] ONE_BYTE_MAX   = 32'd255;
  localparam logic [31:0] TWO_BYTE_MAX   = 32'd65535;

  typedef enum logic [1:0] {
    OP_UINT    = 2'd0,
    OP_OPAQUE  = 2'd1,
    OP_PAYLOAD = 2'd2,
    OP_START   = 2'd3
  } opcode_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  typedef struct packed {
    frame_t           frame;
    logic [CNT_W-1:0] count;
    logic             err;
  } enc_result_t;

endpackage

### rtl/coe_item_if.sv
// Input item channel: option commands with valid/ready handshake.
interface coe_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] option_number;
  logic [31:0] value;
  logic [16:0] payload_length;
  logic [7:0]  data_byte;

  modport source (output valid, opcode, option_number, value, payload_length, data_byte,
                  input ready);
  modport sink (input valid, opcode, option_number, value, payload_length, data_byte,
                output ready);
endinterface

### rtl/coe_byte_if.sv
// Result channel: encoded bytes with valid/ready handshake.
interface coe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       order_error;

  modport source (output valid, out_byte, last, order_error, input ready);
  modport sink (input valid, out_byte, last, order_error, output ready);
endinterface

### rtl/coe_encoder.sv
// Combinational option encoder: builds the byte frame for one input item.
module coe_encoder (
  input  logic [1:0]          opcode,
  input  logic [15:0]         option_number,
  input  logic [31:0]         value,
  input  logic [16:0]         payload_length,
  input  logic [7:0]          data_byte,
  input  logic [15:0]         prev_option,
  output coe_pkg::enc_result_t result,
  output logic                update
);
  import coe_pkg::*;

  function automatic logic [3:0] nibble(input logic [16:0] v);
    logic [3:0] n;
    if (v <= NIB_DIRECT_MAX) n = v[3:0];
    else if (v <= EXT1_MAX) n = NIB_EXT1;
    else n = NIB_EXT2;
    return n;
  endfunction

  function automatic logic [1:0] ext_count(input logic [16:0] v);
    logic [1:0] n;
    if (v <= NIB_DIRECT_MAX) n = 2'd0;
    else if (v <= EXT1_MAX) n = 2'd1;
    else n = 2'd2;
    return n;
  endfunction

  function automatic logic [15:0] ext_word(input logic [16:0] v);
    logic [16:0] d;
    logic [15:0] w;
    if (v <= NIB_DIRECT_MAX) begin
      d = '0;
      w = '0;
    end else if (v <= EXT1_MAX) begin
      d = v - EXT1_BASE;
      w = {8'd0, d[7:0]};
    end else begin
      d = v - EXT2_BASE;
      w = d[15:0];
    end
    return w;
  endfunction

  logic [16:0] delta;
  logic [16:0] len_val;
  logic [2:0]  val_n;
  logic [31:0] val_bytes;
  logic [1:0]  dn;
  logic [1:0]  ln;
  logic [7:0]  hdr;
  logic [63:0] acc1;
  logic [63:0] acc2;
  logic [63:0] acc3;
  logic [63:0] acc4;
  logic        out_of_order;

  always_comb begin
    out_of_order = (option_number < prev_option);
    delta = {1'b0, option_number - prev_option};

    if (value == 32'd0) val_n = 3'd0;
    else if (value <= ONE_BYTE_MAX) val_n = 3'd1;
    else if (value <= TWO_BYTE_MAX) val_n = 3'd2;
    else val_n = 3'd4;

    if (opcode == OP_OPAQUE) begin
      len_val   = (payload_length > MAX_OPAQUE_LEN) ? MAX_OPAQUE_LEN : payload_length;
      val_bytes = '0;
    end else begin
      len_val   = {14'd0, val_n};
      val_bytes = value;
    end

    dn  = ext_count(delta);
    ln  = ext_count(len_val);
    hdr = {nibble(delta), nibble(len_val)};

    acc1 = {56'd0, hdr};
    acc2 = (acc1 << {2'd0, dn, 3'd0}) | {48'd0, ext_word(delta)};
    acc3 = (acc2 << {2'd0, ln, 3'd0}) | {48'd0, ext_word(len_val)};
    if (opcode == OP_OPAQUE) acc4 = acc3;
    else acc4 = (acc3 << {1'b0, val_n, 3'd0}) | {32'd0, val_bytes};
  end

  always_comb begin
    result.frame = frame_t'(acc4);
    result.count = CNT_W'(1) + CNT_W'(dn) + CNT_W'(ln);
    result.err   = 1'b0;
    update       = 1'b0;
    case (opcode)
      OP_START: begin
        result.count = '0;
      end
      OP_PAYLOAD: begin
        result.frame = frame_t'({56'd0, data_byte});
        result.count = CNT_W'(1);
      end
      OP_UINT, OP_OPAQUE: begin
        if (out_of_order) begin
          result.frame = '0;
          result.count = CNT_W'(1);
          result.err   = 1'b1;
        end else begin
          update = 1'b1;
          if (opcode == OP_UINT) begin
            result.count = CNT_W'(1) + CNT_W'(dn) + CNT_W'(val_n);
          end
        end
      end
      default: begin
        result.count = '0;
      end
    endcase
  end

endmodule

### rtl/coe_serializer.sv
// Frame register and byte serializer: emits one encoded byte per transfer.
module coe_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  coe_pkg::enc_result_t result,
  output logic                 can_take,
  coe_byte_if.source           byte_out
);
  import coe_pkg::*;

  logic             valid;
  frame_t           frame;
  logic [IDX_W-1:0] idx;
  logic             err;
  logic             pop;
  logic             done;

  assign pop      = valid && byte_out.ready;
  assign done     = pop && (idx == '0);
  assign can_take = !valid || done;

  assign byte_out.valid       = valid;
  assign byte_out.out_byte    = frame[idx];
  assign byte_out.last        = (idx == '0);
  assign byte_out.order_error = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= IDX_W'(result.count - CNT_W'(1));
    end else if (done) begin
      valid <= 1'b0;
    end else if (pop) begin
      idx   <= idx - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= result.frame;
      err   <= result.err;
    end
  end

endmodule

### rtl/coap_option_encoder.sv
// CoAP option delta/length encoder top level.
// Usage:
//   opt_in carries one command per transfer: a uint option, an opaque option
//   header, an opaque payload byte, or start of a new message.
//   byte_out carries the encoded stream, one byte per transfer; last marks the
//   final byte of a command, order_error marks a rejected out-of-order option
//   (a single zero byte with last set).
// Timing: the first byte of a command is on byte_out in the cycle after its
//   transfer on opt_in. A command holds the frame register until its last
//   byte transfers: 1 to 7 bytes for an option, 1 for a payload byte, none
//   for a start of message, which never loads the frame register.
// Throughput: one output byte per cycle while byte_out.ready is high; the next
//   command is taken in the cycle its predecessor's last byte transfers, so
//   back-to-back commands leave no gap in the stream. Option headers are built
//   combinationally by the encoder between the input and the frame register.
// Reset: rst clears the previous option number to 0 and empties the frame.
// Stall: while byte_out.ready is low the current byte holds and opt_in.ready
//   stays low once a frame is waiting.
module coap_option_encoder (
  input  logic       clk,
  input  logic       rst,
  coe_item_if.sink   opt_in,
  coe_byte_if.source byte_out
);
  import coe_pkg::*;

  logic [15:0] prev_option;
  enc_result_t result;
  logic        update;
  logic        can_take;
  logic        accept;
  logic        load;

  coe_encoder u_encoder (
    .opcode         (opt_in.opcode),
    .option_number  (opt_in.option_number),
    .value          (opt_in.value),
    .payload_length (opt_in.payload_length),
    .data_byte      (opt_in.data_byte),
    .prev_option    (prev_option),
    .result         (result),
    .update         (update)
  );

  coe_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .result   (result),
    .can_take (can_take),
    .byte_out (byte_out)
  );

  assign opt_in.ready = can_take;
  assign accept       = opt_in.valid && can_take;
  assign load         = accept && (result.count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_option <= '0;
    end else if (accept && (opt_in.opcode == OP_START)) begin
      prev_option <= '0;
    end else if (accept && update) begin
      prev_option <= opt_in.option_number;
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    byte_out.valid && byte_out.order_error |-> byte_out.last)
    else $error("order error result without last");

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    accept && (opt_in.opcode == OP_START) |=> prev_option == '0)
    else $error("start of message did not clear previous option");

  a_err_keeps_state: assert property (@(posedge clk) disable iff (rst)
    load && result.err |=> prev_option == $past(prev_option))
    else $error("rejected option changed previous option");

  a_stall_has_data: assert property (@(posedge clk) disable iff (rst)
    !opt_in.ready |-> byte_out.valid)
    else $error("input stalled with no pending byte");

endmodule

### dv/tb_coap_option_encoder.sv
// Self-checking testbench for the CoAP option delta/length encoder.
`timescale 1ns / 100ps

module tb_coap_option_encoder;
  import coe_pkg::*;

  localparam logic [16:0] NIB_LIMIT      = 17'd12;
  localparam logic [16:0] EXT1_OFFSET    = 17'd13;
  localparam logic [16:0] EXT1_LIMIT     = 17'd268;
  localparam logic [16:0] EXT2_OFFSET    = 17'd269;
  localparam logic [16:0] OPAQUE_LEN_MAX = 17'd65804;
  localparam logic [3:0]  NIB_ONE_EXT    = 4'd13;
  localparam logic [3:0]  NIB_TWO_EXT    = 4'd14;
  localparam int          RANDOM_ITEMS   = 350;
  localparam int          QUIET_TAIL     = 40;
  localparam int          CYCLE_LIMIT    = 500000;

  typedef struct {
    opcode_t     op;
    logic [15:0] num;
    logic [31:0] val;
    logic [16:0] plen;
    logic [7:0]  dbyte;
  } option_cmd_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       last;
    logic       order_error;
  } coded_byte_t;

  logic clk;
  logic rst;

  coe_item_if opt_in ();
  coe_byte_if byte_out ();

  coap_option_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .opt_in   (opt_in.sink),
    .byte_out (byte_out.source)
  );

  option_cmd_t pending_cmds[$];
  coded_byte_t coded_bytes[$];
  option_cmd_t cur_cmd;
  logic        cmd_busy;
  int          gap_left;
  int          stall_left;
  int          fail_count;
  int          cmd_count;
  int          cycle_count;
  logic [15:0] prev_opt;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [3:0] nibble_code(input logic [16:0] v);
    if (v <= NIB_LIMIT) return v[3:0];
    if (v <= EXT1_LIMIT) return NIB_ONE_EXT;
    return NIB_TWO_EXT;
  endfunction

  function automatic void push_coded(input logic [7:0] b);
    coded_byte_t cb;
    cb.out_byte    = b;
    cb.last        = 1'b0;
    cb.order_error = 1'b0;
    coded_bytes.push_back(cb);
  endfunction

  function automatic void push_extension(input logic [16:0] v);
    logic [16:0] w;
    if (v > NIB_LIMIT) begin
      if (v <= EXT1_LIMIT) begin
        w = v - EXT1_OFFSET;
        push_coded(w[7:0]);
      end else begin
        w = v - EXT2_OFFSET;
        push_coded(w[15:8]);
        push_coded(w[7:0]);
      end
    end
  endfunction

  function automatic void encode_option(input option_cmd_t c);
    logic [16:0] delta;
    logic [16:0] len;
    coded_byte_t cb;
    int          i;
    case (c.op)
      OP_START: prev_opt = '0;
      OP_PAYLOAD: begin
        cb.out_byte    = c.dbyte;
        cb.last        = 1'b1;
        cb.order_error = 1'b0;
        coded_bytes.push_back(cb);
      end
      default: begin
        if (c.num < prev_opt) begin
          cb.out_byte    = 8'h00;
          cb.last        = 1'b1;
          cb.order_error = 1'b1;
          coded_bytes.push_back(cb);
        end else begin
          delta = {1'b0, c.num} - {1'b0, prev_opt};
          if (c.op == OP_OPAQUE) begin
            len = (c.plen > OPAQUE_LEN_MAX) ? OPAQUE_LEN_MAX : c.plen;
          end else if (c.val == 32'd0) begin
            len = 17'd0;
          end else if (c.val <= 32'd255) begin
            len = 17'd1;
          end else if (c.val <= 32'd65535) begin
            len = 17'd2;
          end else begin
            len = 17'd4;
          end
          push_coded({nibble_code(delta), nibble_code(len)});
          push_extension(delta);
          push_extension(len);
          if (c.op == OP_UINT) begin
            for (i = int'(len) - 1; i >= 0; i--) push_coded(8'(c.val >> (8 * i)));
          end
          cb = coded_bytes.pop_back();
          cb.last = 1'b1;
          coded_bytes.push_back(cb);
          prev_opt = c.num;
        end
      end
    endcase
  endfunction

  task automatic add_cmd(input opcode_t op, input logic [15:0] num, input logic [31:0] val,
                         input logic [16:0] plen, input logic [7:0] dbyte);
    option_cmd_t c;
    c.op    = op;
    c.num   = num;
    c.val   = val;
    c.plen  = plen;
    c.dbyte = dbyte;
    pending_cmds.push_back(c);
    cmd_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      opt_in.valid <= 1'b0;
      cmd_busy = 1'b0;
      gap_left = 0;
    end else begin
      if (opt_in.valid && opt_in.ready) begin
        encode_option(cur_cmd);
        cmd_busy = 1'b0;
      end
      if (!cmd_busy) begin
        if (gap_left != 0) begin
          gap_left--;
          opt_in.valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cur_cmd = pending_cmds.pop_front();
          cmd_busy = 1'b1;
          opt_in.valid          <= 1'b1;
          opt_in.opcode         <= cur_cmd.op;
          opt_in.option_number  <= cur_cmd.num;
          opt_in.value          <= cur_cmd.val;
          opt_in.payload_length <= cur_cmd.plen;
          opt_in.data_byte      <= cur_cmd.dbyte;
          if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 3) == 0) begin
            gap_left = $urandom_range(1, 12);
          end
        end else begin
          opt_in.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    coded_byte_t want;
    if (rst) begin
      byte_out.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (byte_out.valid && byte_out.ready) begin
        if (coded_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %0h last %0b order_error %0b",
                 byte_out.out_byte, byte_out.last, byte_out.order_error);
          fail_count++;
        end else begin
          want = coded_bytes.pop_front();
          if (byte_out.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, byte_out.out_byte);
            fail_count++;
          end
          if (byte_out.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, byte_out.last);
            fail_count++;
          end
          if (byte_out.order_error !== want.order_error) begin
            $error("order_error: expected %0b, got %0b", want.order_error,
                   byte_out.order_error);
            fail_count++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        byte_out.ready <= 1'b0;
      end else begin
        byte_out.ready <= 1'b1;
        if (pending_cmds.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("coap_option_encoder regression: fail");
      $finish;
    end
  end

  initial begin
    int          gen_prev;
    int          delta;
    int          num;
    int          pick;
    int          n_opts;
    int          k;
    logic [31:0] val;
    logic [16:0] plen;

    clk                   = 1'b0;
    rst                   = 1'b1;
    opt_in.valid          = 1'b0;
    opt_in.opcode         = OP_START;
    opt_in.option_number  = '0;
    opt_in.value          = '0;
    opt_in.payload_length = '0;
    opt_in.data_byte      = '0;
    byte_out.ready        = 1'b0;
    fail_count            = 0;
    cmd_count             = 0;
    cycle_count           = 0;
    prev_opt              = '0;
    cmd_busy              = 1'b0;

    add_cmd(OP_START, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd0, 32'd0, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd12, 32'd1, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd25, 32'd255, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd293, 32'd256, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd562, 32'd65535, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd65535, 32'd65536, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd65535, 32'hFFFF_FFFF, 17'($urandom()), 8'($urandom()));
    add_cmd(OP_UINT, 16'd100, $urandom(), 17'($urandom()), 8'($urandom()));
    add_cmd(OP_START, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd65535, $urandom(), 17'd0, 8'($urandom()));
    add_cmd(OP_START, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd1, $urandom(), 17'd12, 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd1, $urandom(), 17'd13, 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd2, $urandom(), 17'd268, 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd3, $urandom(), 17'd269, 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd4, $urandom(), OPAQUE_LEN_MAX, 8'($urandom()));
    add_cmd(OP_PAYLOAD, 16'($urandom()), $urandom(), 17'($urandom()), 8'h00);
    add_cmd(OP_PAYLOAD, 16'($urandom()), $urandom(), 17'($urandom()), 8'hFF);
    add_cmd(OP_OPAQUE, 16'd5, $urandom(), 17'd65805, 8'($urandom()));
    add_cmd(OP_OPAQUE, 16'd5, $urandom(), 17'h1FFFF, 8'($urandom()));
    add_cmd(OP_PAYLOAD, 16'($urandom()), $urandom(), 17'($urandom()), 8'hA5);
    add_cmd(OP_OPAQUE, 16'd4, $urandom(), 17'($urandom()), 8'($urandom()));
    add_cmd(OP_START, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));

    gen_prev = 0;
    k = cmd_count + RANDOM_ITEMS;
    while (cmd_count < k) begin
      if ($urandom_range(0, 7) != 0) begin
        add_cmd(OP_START, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));
        gen_prev = 0;
      end
      n_opts = $urandom_range(1, 8);
      repeat (n_opts) begin
        pick = $urandom_range(0, 19);
        if (pick == 0 && gen_prev != 0) begin
          add_cmd(($urandom_range(0, 1) != 0) ? OP_OPAQUE : OP_UINT,
                  16'($urandom_range(0, gen_prev - 1)), $urandom(), 17'($urandom()),
                  8'($urandom()));
        end else if (pick <= 1) begin
          add_cmd(OP_PAYLOAD, 16'($urandom()), $urandom(), 17'($urandom()), 8'($urandom()));
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: delta = $urandom_range(0, 12);
            4, 5, 6:    delta = $urandom_range(13, 268);
            7, 8:       delta = $urandom_range(269, 65535);
            default:    delta = $urandom_range(0, 65535);
          endcase
          num = (gen_prev + delta > 65535) ? $urandom_range(gen_prev, 65535) : gen_prev + delta;
          if (pick < 11) begin
            case ($urandom_range(0, 4))
              0:       val = 32'd0;
              1:       val = $urandom_range(1, 255);
              2:       val = $urandom_range(256, 65535);
              3:       val = $urandom_range(65536, 32'hFFFF_FFFF);
              default: val = $urandom();
            endcase
            add_cmd(OP_UINT, 16'(num), val, 17'($urandom()), 8'($urandom()));
          end else begin
            case ($urandom_range(0, 7))
              0, 1, 2: plen = 17'($urandom_range(0, 12));
              3, 4:    plen = 17'($urandom_range(13, 268));
              5, 6:    plen = 17'($urandom_range(269, 65804));
              default: plen = 17'($urandom_range(65805, 131071));
            endcase
            add_cmd(OP_OPAQUE, 16'(num), $urandom(), plen, 8'($urandom()));
            repeat ($urandom_range(0, 5)) begin
              add_cmd(OP_PAYLOAD, 16'($urandom()), $urandom(), 17'($urandom()),
                      8'($urandom()));
            end
          end
          gen_prev = num;
        end
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || cmd_busy || coded_bytes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (coded_bytes.size() != 0) begin
      $error("bytes still outstanding: %0d", coded_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("coap_option_encoder regression: pass");
    end else begin
      $display("coap_option_encoder regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/coe_pkg.sv
rtl/coe_item_if.sv
rtl/coe_byte_if.sv
rtl/coe_encoder.sv
rtl/coe_serializer.sv
rtl/coap_option_encoder.sv
dv/tb_coap_option_encoder.sv
